@@ rtl/ppcd_pkg.sv @@
`default_nettype none

package ppcd_pkg;

    // mnemonic numbers, dense, 0 means not recognized
    localparam logic [6:0] MN_NONE      = 7'd0;
    localparam logic [6:0] MN_CMP       = 7'd1;
    localparam logic [6:0] MN_TW        = 7'd2;
    localparam logic [6:0] MN_SUBFC     = 7'd3;
    localparam logic [6:0] MN_MULHDU    = 7'd4;
    localparam logic [6:0] MN_ADDC      = 7'd5;
    localparam logic [6:0] MN_MULHWU    = 7'd6;
    localparam logic [6:0] MN_MFCR      = 7'd7;
    localparam logic [6:0] MN_MFOCRF    = 7'd8;
    localparam logic [6:0] MN_LWARX     = 7'd9;
    localparam logic [6:0] MN_LDX       = 7'd10;
    localparam logic [6:0] MN_LWZX      = 7'd11;
    localparam logic [6:0] MN_SLW       = 7'd12;
    localparam logic [6:0] MN_CNTLZW    = 7'd13;
    localparam logic [6:0] MN_SLD       = 7'd14;
    localparam logic [6:0] MN_AND       = 7'd15;
    localparam logic [6:0] MN_CMPL      = 7'd16;
    localparam logic [6:0] MN_SUBF      = 7'd17;
    localparam logic [6:0] MN_LWZUX     = 7'd18;
    localparam logic [6:0] MN_MULHD     = 7'd19;
    localparam logic [6:0] MN_MULHW     = 7'd20;
    localparam logic [6:0] MN_MFMSR     = 7'd21;
    localparam logic [6:0] MN_NEG       = 7'd22;
    localparam logic [6:0] MN_SUBFE     = 7'd23;
    localparam logic [6:0] MN_ADDE      = 7'd24;
    localparam logic [6:0] MN_MTMSR     = 7'd25;
    localparam logic [6:0] MN_SUBFZE    = 7'd26;
    localparam logic [6:0] MN_ADDZE     = 7'd27;
    localparam logic [6:0] MN_SUBFME    = 7'd28;
    localparam logic [6:0] MN_MULLD     = 7'd29;
    localparam logic [6:0] MN_ADDME     = 7'd30;
    localparam logic [6:0] MN_MULLW     = 7'd31;
    localparam logic [6:0] MN_ADD       = 7'd32;
    localparam logic [6:0] MN_MFXER     = 7'd33;
    localparam logic [6:0] MN_MFLR      = 7'd34;
    localparam logic [6:0] MN_MFCTR     = 7'd35;
    localparam logic [6:0] MN_MFSPR     = 7'd36;
    localparam logic [6:0] MN_MR        = 7'd37;
    localparam logic [6:0] MN_OR        = 7'd38;
    localparam logic [6:0] MN_DIVDU     = 7'd39;
    localparam logic [6:0] MN_DIVWU     = 7'd40;
    localparam logic [6:0] MN_MTXER     = 7'd41;
    localparam logic [6:0] MN_MTLR      = 7'd42;
    localparam logic [6:0] MN_MTCTR     = 7'd43;
    localparam logic [6:0] MN_MTSPR     = 7'd44;
    localparam logic [6:0] MN_DIVD      = 7'd45;
    localparam logic [6:0] MN_DIVW      = 7'd46;
    localparam logic [6:0] MN_SRAW      = 7'd47;
    localparam logic [6:0] MN_SRAD      = 7'd48;
    localparam logic [6:0] MN_SRAWI     = 7'd49;
    localparam logic [6:0] MN_EXTSH     = 7'd50;
    localparam logic [6:0] MN_EXTSB     = 7'd51;
    localparam logic [6:0] MN_EXTSW     = 7'd52;
    localparam logic [6:0] MN_MCRF      = 7'd53;
    localparam logic [6:0] MN_RFID      = 7'd54;
    localparam logic [6:0] MN_ISYNC     = 7'd55;
    localparam logic [6:0] MN_HRFID     = 7'd56;
    localparam logic [6:0] MN_BCLR      = 7'd57;
    localparam logic [6:0] MN_BCCTR     = 7'd58;
    localparam logic [6:0] MN_CRNOR     = 7'd59;
    localparam logic [6:0] MN_CRANDC    = 7'd60;
    localparam logic [6:0] MN_CRXOR     = 7'd61;
    localparam logic [6:0] MN_CRNAND    = 7'd62;
    localparam logic [6:0] MN_CRAND     = 7'd63;
    localparam logic [6:0] MN_CREQV     = 7'd64;
    localparam logic [6:0] MN_CRORC     = 7'd65;
    localparam logic [6:0] MN_CROR      = 7'd66;
    localparam logic [6:0] MN_TDI       = 7'd67;
    localparam logic [6:0] MN_TWI       = 7'd68;
    localparam logic [6:0] MN_MULLI     = 7'd69;
    localparam logic [6:0] MN_SUBFIC    = 7'd70;
    localparam logic [6:0] MN_CMPLI     = 7'd71;
    localparam logic [6:0] MN_CMPI      = 7'd72;
    localparam logic [6:0] MN_ADDIC     = 7'd73;
    localparam logic [6:0] MN_ADDIC_RC  = 7'd74;
    localparam logic [6:0] MN_ADDI      = 7'd75;
    localparam logic [6:0] MN_ADDIS     = 7'd76;
    localparam logic [6:0] MN_BC        = 7'd77;
    localparam logic [6:0] MN_B         = 7'd78;
    localparam logic [6:0] MN_RLWIMI    = 7'd79;
    localparam logic [6:0] MN_RLWINM    = 7'd80;
    localparam logic [6:0] MN_RLWNM     = 7'd81;
    localparam logic [6:0] MN_ORI       = 7'd82;
    localparam logic [6:0] MN_ORIS      = 7'd83;
    localparam logic [6:0] MN_XORI      = 7'd84;
    localparam logic [6:0] MN_XORIS     = 7'd85;
    localparam logic [6:0] MN_ANDI_RC   = 7'd86;
    localparam logic [6:0] MN_ANDIS_RC  = 7'd87;
    localparam logic [6:0] MN_LWZ       = 7'd88;
    localparam logic [6:0] MN_LWZU      = 7'd89;
    localparam logic [6:0] MN_LBZ       = 7'd90;
    localparam logic [6:0] MN_LBZU      = 7'd91;
    localparam logic [6:0] MN_STW       = 7'd92;
    localparam logic [6:0] MN_STWU      = 7'd93;
    localparam logic [6:0] MN_STB       = 7'd94;
    localparam logic [6:0] MN_STBU      = 7'd95;
    localparam logic [6:0] MN_LHZ       = 7'd96;
    localparam logic [6:0] MN_LHZU      = 7'd97;
    localparam logic [6:0] MN_LHA       = 7'd98;
    localparam logic [6:0] MN_LHAU      = 7'd99;
    localparam logic [6:0] MN_STH       = 7'd100;
    localparam logic [6:0] MN_STHU      = 7'd101;
    localparam logic [6:0] MN_LMW       = 7'd102;
    localparam logic [6:0] MN_STMW      = 7'd103;
    localparam logic [6:0] MN_LFS       = 7'd104;
    localparam logic [6:0] MN_LFSU      = 7'd105;
    localparam logic [6:0] MN_LFD       = 7'd106;
    localparam logic [6:0] MN_LFDU      = 7'd107;
    localparam logic [6:0] MN_STFS      = 7'd108;
    localparam logic [6:0] MN_STFSU     = 7'd109;
    localparam logic [6:0] MN_STFD      = 7'd110;
    localparam logic [6:0] MN_STFDU     = 7'd111;
    localparam logic [6:0] MN_LD        = 7'd112;
    localparam logic [6:0] MN_LDU       = 7'd113;
    localparam logic [6:0] MN_LWA       = 7'd114;
    localparam logic [6:0] MN_STD       = 7'd115;
    localparam logic [6:0] MN_STDU      = 7'd116;

    // primary opcodes
    localparam logic [5:0] OP_TDI      = 6'd2;
    localparam logic [5:0] OP_TWI      = 6'd3;
    localparam logic [5:0] OP_MULLI    = 6'd7;
    localparam logic [5:0] OP_SUBFIC   = 6'd8;
    localparam logic [5:0] OP_CMPLI    = 6'd10;
    localparam logic [5:0] OP_CMPI     = 6'd11;
    localparam logic [5:0] OP_ADDIC    = 6'd12;
    localparam logic [5:0] OP_ADDIC_RC = 6'd13;
    localparam logic [5:0] OP_ADDI     = 6'd14;
    localparam logic [5:0] OP_ADDIS    = 6'd15;
    localparam logic [5:0] OP_BC       = 6'd16;
    localparam logic [5:0] OP_B        = 6'd18;
    localparam logic [5:0] OP_GRP19    = 6'd19;
    localparam logic [5:0] OP_RLWIMI   = 6'd20;
    localparam logic [5:0] OP_RLWINM   = 6'd21;
    localparam logic [5:0] OP_RLWNM    = 6'd23;
    localparam logic [5:0] OP_ORI      = 6'd24;
    localparam logic [5:0] OP_ORIS     = 6'd25;
    localparam logic [5:0] OP_XORI     = 6'd26;
    localparam logic [5:0] OP_XORIS    = 6'd27;
    localparam logic [5:0] OP_ANDI_RC  = 6'd28;
    localparam logic [5:0] OP_ANDIS_RC = 6'd29;
    localparam logic [5:0] OP_GRP31    = 6'd31;
    localparam logic [5:0] OP_LWZ      = 6'd32;
    localparam logic [5:0] OP_LWZU     = 6'd33;
    localparam logic [5:0] OP_LBZ      = 6'd34;
    localparam logic [5:0] OP_LBZU     = 6'd35;
    localparam logic [5:0] OP_STW      = 6'd36;
    localparam logic [5:0] OP_STWU     = 6'd37;
    localparam logic [5:0] OP_STB      = 6'd38;
    localparam logic [5:0] OP_STBU     = 6'd39;
    localparam logic [5:0] OP_LHZ      = 6'd40;
    localparam logic [5:0] OP_LHZU     = 6'd41;
    localparam logic [5:0] OP_LHA      = 6'd42;
    localparam logic [5:0] OP_LHAU     = 6'd43;
    localparam logic [5:0] OP_STH      = 6'd44;
    localparam logic [5:0] OP_STHU     = 6'd45;
    localparam logic [5:0] OP_LMW      = 6'd46;
    localparam logic [5:0] OP_STMW     = 6'd47;
    localparam logic [5:0] OP_LFS      = 6'd48;
    localparam logic [5:0] OP_LFSU     = 6'd49;
    localparam logic [5:0] OP_LFD      = 6'd50;
    localparam logic [5:0] OP_LFDU     = 6'd51;
    localparam logic [5:0] OP_STFS     = 6'd52;
    localparam logic [5:0] OP_STFSU    = 6'd53;
    localparam logic [5:0] OP_STFD     = 6'd54;
    localparam logic [5:0] OP_STFDU    = 6'd55;
    localparam logic [5:0] OP_DS_LOAD  = 6'd58;
    localparam logic [5:0] OP_DS_STORE = 6'd62;

    // extended opcodes under primary 19
    localparam logic [9:0] XO19_MCRF   = 10'd0;
    localparam logic [9:0] XO19_BCLR   = 10'd16;
    localparam logic [9:0] XO19_RFID   = 10'd18;
    localparam logic [9:0] XO19_CRNOR  = 10'd33;
    localparam logic [9:0] XO19_CRANDC = 10'd129;
    localparam logic [9:0] XO19_ISYNC  = 10'd150;
    localparam logic [9:0] XO19_CRXOR  = 10'd193;
    localparam logic [9:0] XO19_CRNAND = 10'd225;
    localparam logic [9:0] XO19_CRAND  = 10'd257;
    localparam logic [9:0] XO19_HRFID  = 10'd274;
    localparam logic [9:0] XO19_CREQV  = 10'd289;
    localparam logic [9:0] XO19_CRORC  = 10'd417;
    localparam logic [9:0] XO19_CROR   = 10'd449;
    localparam logic [9:0] XO19_BCCTR  = 10'd528;

    // extended opcodes under primary 31, full 10-bit field
    localparam logic [9:0] XO31_CMP    = 10'd0;
    localparam logic [9:0] XO31_TW     = 10'd4;
    localparam logic [9:0] XO31_MULHDU = 10'd9;
    localparam logic [9:0] XO31_MULHWU = 10'd11;
    localparam logic [9:0] XO31_MFCR   = 10'd19;
    localparam logic [9:0] XO31_LWARX  = 10'd20;
    localparam logic [9:0] XO31_LDX    = 10'd21;
    localparam logic [9:0] XO31_LWZX   = 10'd23;
    localparam logic [9:0] XO31_SLW    = 10'd24;
    localparam logic [9:0] XO31_CNTLZW = 10'd26;
    localparam logic [9:0] XO31_SLD    = 10'd27;
    localparam logic [9:0] XO31_AND    = 10'd28;
    localparam logic [9:0] XO31_CMPL   = 10'd32;
    localparam logic [9:0] XO31_LWZUX  = 10'd55;
    localparam logic [9:0] XO31_MULHD  = 10'd73;
    localparam logic [9:0] XO31_MULHW  = 10'd75;
    localparam logic [9:0] XO31_MFMSR  = 10'd83;
    localparam logic [9:0] XO31_MTMSR  = 10'd146;
    localparam logic [9:0] XO31_MFSPR  = 10'd339;
    localparam logic [9:0] XO31_OR     = 10'd444;
    localparam logic [9:0] XO31_MTSPR  = 10'd467;
    localparam logic [9:0] XO31_SRAW   = 10'd792;
    localparam logic [9:0] XO31_SRAD   = 10'd794;
    localparam logic [9:0] XO31_SRAWI  = 10'd824;
    localparam logic [9:0] XO31_EXTSH  = 10'd922;
    localparam logic [9:0] XO31_EXTSB  = 10'd954;
    localparam logic [9:0] XO31_EXTSW  = 10'd986;

    // xo-form arithmetic under primary 31, 9-bit field without oe
    localparam logic [8:0] XOA_SUBFC  = 9'd8;
    localparam logic [8:0] XOA_ADDC   = 9'd10;
    localparam logic [8:0] XOA_SUBF   = 9'd40;
    localparam logic [8:0] XOA_NEG    = 9'd104;
    localparam logic [8:0] XOA_SUBFE  = 9'd136;
    localparam logic [8:0] XOA_ADDE   = 9'd138;
    localparam logic [8:0] XOA_SUBFZE = 9'd200;
    localparam logic [8:0] XOA_ADDZE  = 9'd202;
    localparam logic [8:0] XOA_SUBFME = 9'd232;
    localparam logic [8:0] XOA_MULLD  = 9'd233;
    localparam logic [8:0] XOA_ADDME  = 9'd234;
    localparam logic [8:0] XOA_MULLW  = 9'd235;
    localparam logic [8:0] XOA_ADD    = 9'd266;
    localparam logic [8:0] XOA_DIVDU  = 9'd457;
    localparam logic [8:0] XOA_DIVWU  = 9'd459;
    localparam logic [8:0] XOA_DIVD   = 9'd489;
    localparam logic [8:0] XOA_DIVW   = 9'd491;

    // spr numbers that have alias mnemonics
    localparam logic [9:0] SPR_XER = 10'd1;
    localparam logic [9:0] SPR_LR  = 10'd8;
    localparam logic [9:0] SPR_CTR = 10'd9;

    // suffix flag positions
    localparam int unsigned SUF_O   = 0;
    localparam int unsigned SUF_DOT = 1;
    localparam int unsigned SUF_L   = 2;
    localparam int unsigned SUF_A   = 3;

    // decoded fields carried down the pipe
    typedef struct packed {
        logic [6:0]  mnemonic;
        logic [24:0] reg_fields;
        logic [15:0] immediate;
        logic [9:0]  special_reg;
        logic [3:0]  suffix_bits;
        logic        is_branch;
        logic        absolute;
    } ppcd_dec_t;

endpackage

`default_nettype wire

@@ rtl/powerpc_instruction_decoder_top.sv @@
`default_nettype none

// channel   | signals                                  | transaction
// ----------+------------------------------------------+------------------------------
// command   | start, busy, instr_word, pc              | start high while busy low
// result    | done, recognized, mnemonic, reg_one..    | done high for one cycle
//           | reg_five, immediate, special_reg,        |
//           | suffix_bits, branch_target               |
//
// one instruction per cycle; each command passes through registered stages 1 to 3 in order:
// stage 1 decodes the word, stage 2 adds the low 32 bits of the branch target,
// stage 3 adds the high 32 bits with the carry and drives the result ports
// busy is always low: the pipe never stalls and results cannot be held off
// rst_n clears the valid bits only; payload registers carry no reset
module powerpc_instruction_decoder_top
    import ppcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] instr_word,
    input  wire logic [63:0] pc,
    output logic             done,
    output logic             recognized,
    output logic [6:0]       mnemonic,
    output logic [4:0]       reg_one,
    output logic [4:0]       reg_two,
    output logic [4:0]       reg_three,
    output logic [4:0]       reg_four,
    output logic [4:0]       reg_five,
    output logic [15:0]      immediate,
    output logic [9:0]       special_reg,
    output logic [3:0]       suffix_bits,
    output logic [63:0]      branch_target
);

    // ---------------------------------------------------------------
    // stage 1: classify the instruction word
    // ---------------------------------------------------------------
    logic [5:0]  op;
    logic [9:0]  xo;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [9:0]  spr_num;
    logic        xo_hit;
    logic [63:0] disp;
    ppcd_dec_t   dec;

    assign op      = instr_word[31:26];
    assign xo      = instr_word[10:1];
    assign rd      = instr_word[25:21];
    assign ra      = instr_word[20:16];
    assign rb      = instr_word[15:11];
    // spr field has its two halves swapped in the encoding
    assign spr_num = {rb, ra};

    always_comb
    begin
        dec             = '0;
        dec.immediate   = instr_word[15:0];
        dec.reg_fields  = instr_word[25:1];
        disp            = '0;
        xo_hit          = 1'b0;
        case (op)
            OP_CMPLI:
            begin
                if (!instr_word[22])
                begin
                    dec.mnemonic = MN_CMPLI;
                end
            end
            OP_CMPI:
            begin
                if (!instr_word[22])
                begin
                    dec.mnemonic = MN_CMPI;
                end
            end
            OP_BC:
            begin
                dec.mnemonic           = MN_BC;
                dec.is_branch          = 1'b1;
                dec.absolute           = instr_word[1];
                dec.suffix_bits[SUF_A] = instr_word[1];
                dec.suffix_bits[SUF_L] = instr_word[0];
                disp = {{48{instr_word[15]}}, instr_word[15:2], 2'b00};
            end
            OP_B:
            begin
                dec.mnemonic           = MN_B;
                dec.is_branch          = 1'b1;
                dec.absolute           = instr_word[1];
                dec.suffix_bits[SUF_A] = instr_word[1];
                dec.suffix_bits[SUF_L] = instr_word[0];
                disp = {{38{instr_word[25]}}, instr_word[25:2], 2'b00};
            end
            OP_GRP19:
            begin
                case (xo)
                    XO19_MCRF:   dec.mnemonic = MN_MCRF;
                    XO19_RFID:   dec.mnemonic = MN_RFID;
                    XO19_ISYNC:  dec.mnemonic = MN_ISYNC;
                    XO19_HRFID:  dec.mnemonic = MN_HRFID;
                    XO19_BCLR:
                    begin
                        dec.mnemonic           = MN_BCLR;
                        dec.suffix_bits[SUF_L] = instr_word[0];
                    end
                    XO19_BCCTR:
                    begin
                        dec.mnemonic           = MN_BCCTR;
                        dec.suffix_bits[SUF_L] = instr_word[0];
                    end
                    XO19_CRNOR:  dec.mnemonic = MN_CRNOR;
                    XO19_CRANDC: dec.mnemonic = MN_CRANDC;
                    XO19_CRXOR:  dec.mnemonic = MN_CRXOR;
                    XO19_CRNAND: dec.mnemonic = MN_CRNAND;
                    XO19_CRAND:  dec.mnemonic = MN_CRAND;
                    XO19_CREQV:  dec.mnemonic = MN_CREQV;
                    XO19_CRORC:  dec.mnemonic = MN_CRORC;
                    XO19_CROR:   dec.mnemonic = MN_CROR;
                    default:     dec.mnemonic = MN_NONE;
                endcase
            end
            OP_GRP31:
            begin
                xo_hit = 1'b1;
                case (xo)
                    XO31_CMP:    dec.mnemonic = MN_CMP;
                    XO31_TW:     dec.mnemonic = MN_TW;
                    XO31_MULHDU: dec.mnemonic = MN_MULHDU;
                    XO31_MULHWU: dec.mnemonic = MN_MULHWU;
                    XO31_MULHD:  dec.mnemonic = MN_MULHD;
                    XO31_MULHW:  dec.mnemonic = MN_MULHW;
                    XO31_MFCR:
                    begin
                        // bit 11 of the encoding picks the one-field form
                        if (instr_word[20])
                        begin
                            dec.mnemonic    = MN_MFOCRF;
                            dec.special_reg = {2'b00, instr_word[19:12]};
                        end
                        else
                        begin
                            dec.mnemonic = MN_MFCR;
                        end
                    end
                    XO31_LWARX:  dec.mnemonic = MN_LWARX;
                    XO31_LDX:    dec.mnemonic = MN_LDX;
                    XO31_LWZX:   dec.mnemonic = MN_LWZX;
                    XO31_LWZUX:
                    begin
                        if (ra != 5'd0 && ra != rd)
                        begin
                            dec.mnemonic = MN_LWZUX;
                        end
                    end
                    XO31_SLW:    dec.mnemonic = MN_SLW;
                    XO31_CNTLZW: dec.mnemonic = MN_CNTLZW;
                    XO31_SLD:    dec.mnemonic = MN_SLD;
                    XO31_AND:    dec.mnemonic = MN_AND;
                    XO31_CMPL:   dec.mnemonic = MN_CMPL;
                    XO31_MFMSR:  dec.mnemonic = MN_MFMSR;
                    XO31_MTMSR:  dec.mnemonic = MN_MTMSR;
                    XO31_MFSPR:
                    begin
                        dec.special_reg = spr_num;
                        dec.mnemonic    = (spr_num == SPR_XER) ? MN_MFXER :
                                          (spr_num == SPR_LR)  ? MN_MFLR  :
                                          (spr_num == SPR_CTR) ? MN_MFCTR : MN_MFSPR;
                    end
                    XO31_MTSPR:
                    begin
                        dec.special_reg = spr_num;
                        dec.mnemonic    = (spr_num == SPR_XER) ? MN_MTXER :
                                          (spr_num == SPR_LR)  ? MN_MTLR  :
                                          (spr_num == SPR_CTR) ? MN_MTCTR : MN_MTSPR;
                    end
                    XO31_OR:     dec.mnemonic = (rd == rb) ? MN_MR : MN_OR;
                    XO31_SRAW:   dec.mnemonic = MN_SRAW;
                    XO31_SRAD:   dec.mnemonic = MN_SRAD;
                    XO31_SRAWI:  dec.mnemonic = MN_SRAWI;
                    XO31_EXTSH:  dec.mnemonic = MN_EXTSH;
                    XO31_EXTSB:  dec.mnemonic = MN_EXTSB;
                    XO31_EXTSW:  dec.mnemonic = MN_EXTSW;
                    default:     xo_hit       = 1'b0;
                endcase
                // record flag for the shift, logic and multiply-high group
                case (xo)
                    XO31_MULHDU, XO31_MULHWU, XO31_MULHD, XO31_MULHW,
                    XO31_SLW, XO31_CNTLZW, XO31_SLD, XO31_AND,
                    XO31_SRAW, XO31_SRAD, XO31_SRAWI,
                    XO31_EXTSH, XO31_EXTSB, XO31_EXTSW:
                        dec.suffix_bits[SUF_DOT] = instr_word[0];
                    default:
                        dec.suffix_bits[SUF_DOT] = 1'b0;
                endcase
                // xo-form arithmetic ignores the oe bit in the match
                if (!xo_hit)
                begin
                    case (xo[8:0])
                        XOA_SUBFC:  dec.mnemonic = MN_SUBFC;
                        XOA_ADDC:   dec.mnemonic = MN_ADDC;
                        XOA_SUBF:   dec.mnemonic = MN_SUBF;
                        XOA_NEG:    dec.mnemonic = MN_NEG;
                        XOA_SUBFE:  dec.mnemonic = MN_SUBFE;
                        XOA_ADDE:   dec.mnemonic = MN_ADDE;
                        XOA_SUBFZE: dec.mnemonic = MN_SUBFZE;
                        XOA_ADDZE:  dec.mnemonic = MN_ADDZE;
                        XOA_SUBFME: dec.mnemonic = MN_SUBFME;
                        XOA_MULLD:  dec.mnemonic = MN_MULLD;
                        XOA_ADDME:  dec.mnemonic = MN_ADDME;
                        XOA_MULLW:  dec.mnemonic = MN_MULLW;
                        XOA_ADD:    dec.mnemonic = MN_ADD;
                        XOA_DIVDU:  dec.mnemonic = MN_DIVDU;
                        XOA_DIVWU:  dec.mnemonic = MN_DIVWU;
                        XOA_DIVD:   dec.mnemonic = MN_DIVD;
                        XOA_DIVW:   dec.mnemonic = MN_DIVW;
                        default:    dec.mnemonic = MN_NONE;
                    endcase
                    if (dec.mnemonic != MN_NONE)
                    begin
                        dec.suffix_bits[SUF_DOT] = instr_word[0];
                        dec.suffix_bits[SUF_O]   = instr_word[10];
                    end
                end
            end
            OP_DS_LOAD:
            begin
                dec.immediate = {instr_word[15:2], 2'b00};
                case (instr_word[1:0])
                    2'd0:    dec.mnemonic = MN_LD;
                    2'd1:    dec.mnemonic = (ra != 5'd0 && ra != rd) ? MN_LDU : MN_NONE;
                    2'd2:    dec.mnemonic = MN_LWA;
                    default: dec.mnemonic = MN_NONE;
                endcase
            end
            OP_DS_STORE:
            begin
                dec.immediate = {instr_word[15:2], 2'b00};
                case (instr_word[1:0])
                    2'd0:    dec.mnemonic = MN_STD;
                    2'd1:    dec.mnemonic = (ra != 5'd0) ? MN_STDU : MN_NONE;
                    default: dec.mnemonic = MN_NONE;
                endcase
            end
            // load updates: base must be nonzero and differ from the target
            OP_LWZU: dec.mnemonic = (ra != 5'd0 && ra != rd) ? MN_LWZU : MN_NONE;
            OP_LBZU: dec.mnemonic = (ra != 5'd0 && ra != rd) ? MN_LBZU : MN_NONE;
            OP_LHZU: dec.mnemonic = (ra != 5'd0 && ra != rd) ? MN_LHZU : MN_NONE;
            OP_LHAU: dec.mnemonic = (ra != 5'd0 && ra != rd) ? MN_LHAU : MN_NONE;
            // store and float updates: base must be nonzero
            OP_STWU:  dec.mnemonic = (ra != 5'd0) ? MN_STWU  : MN_NONE;
            OP_STBU:  dec.mnemonic = (ra != 5'd0) ? MN_STBU  : MN_NONE;
            OP_STHU:  dec.mnemonic = (ra != 5'd0) ? MN_STHU  : MN_NONE;
            OP_LFSU:  dec.mnemonic = (ra != 5'd0) ? MN_LFSU  : MN_NONE;
            OP_LFDU:  dec.mnemonic = (ra != 5'd0) ? MN_LFDU  : MN_NONE;
            OP_STFSU: dec.mnemonic = (ra != 5'd0) ? MN_STFSU : MN_NONE;
            OP_STFDU: dec.mnemonic = (ra != 5'd0) ? MN_STFDU : MN_NONE;
            OP_LMW:   dec.mnemonic = (ra < rd) ? MN_LMW : MN_NONE;
            OP_RLWIMI:
            begin
                dec.mnemonic             = MN_RLWIMI;
                dec.suffix_bits[SUF_DOT] = instr_word[0];
            end
            OP_RLWINM:
            begin
                dec.mnemonic             = MN_RLWINM;
                dec.suffix_bits[SUF_DOT] = instr_word[0];
            end
            OP_RLWNM:
            begin
                dec.mnemonic             = MN_RLWNM;
                dec.suffix_bits[SUF_DOT] = instr_word[0];
            end
            OP_TDI:      dec.mnemonic = MN_TDI;
            OP_TWI:      dec.mnemonic = MN_TWI;
            OP_MULLI:    dec.mnemonic = MN_MULLI;
            OP_SUBFIC:   dec.mnemonic = MN_SUBFIC;
            OP_ADDIC:    dec.mnemonic = MN_ADDIC;
            OP_ADDIC_RC: dec.mnemonic = MN_ADDIC_RC;
            OP_ADDI:     dec.mnemonic = MN_ADDI;
            OP_ADDIS:    dec.mnemonic = MN_ADDIS;
            OP_ORI:      dec.mnemonic = MN_ORI;
            OP_ORIS:     dec.mnemonic = MN_ORIS;
            OP_XORI:     dec.mnemonic = MN_XORI;
            OP_XORIS:    dec.mnemonic = MN_XORIS;
            OP_ANDI_RC:  dec.mnemonic = MN_ANDI_RC;
            OP_ANDIS_RC: dec.mnemonic = MN_ANDIS_RC;
            OP_LWZ:      dec.mnemonic = MN_LWZ;
            OP_LBZ:      dec.mnemonic = MN_LBZ;
            OP_STW:      dec.mnemonic = MN_STW;
            OP_STB:      dec.mnemonic = MN_STB;
            OP_LHZ:      dec.mnemonic = MN_LHZ;
            OP_LHA:      dec.mnemonic = MN_LHA;
            OP_STH:      dec.mnemonic = MN_STH;
            OP_STMW:     dec.mnemonic = MN_STMW;
            OP_LFS:      dec.mnemonic = MN_LFS;
            OP_LFD:      dec.mnemonic = MN_LFD;
            OP_STFS:     dec.mnemonic = MN_STFS;
            OP_STFD:     dec.mnemonic = MN_STFD;
            default:     dec.mnemonic = MN_NONE;
        endcase
    end

    // an unrecognized word reports all fields as zero
    ppcd_dec_t   s1_dec_next;
    logic [63:0] s1_disp_next;
    logic [63:0] s1_pc_next;

    always_comb
    begin
        if (dec.mnemonic == MN_NONE)
        begin
            s1_dec_next  = '0;
            s1_disp_next = '0;
            s1_pc_next   = '0;
        end
        else
        begin
            s1_dec_next  = dec;
            s1_disp_next = disp;
            s1_pc_next   = pc;
        end
    end

    logic        s1_valid_reg;
    ppcd_dec_t   s1_dec_reg;
    logic [63:0] s1_disp_reg;
    logic [63:0] s1_pc_reg;

    // ---------------------------------------------------------------
    // stage 2: low half of pc plus displacement
    // ---------------------------------------------------------------
    logic [32:0] lo_sum_next;

    assign lo_sum_next = {1'b0, s1_pc_reg[31:0]} + {1'b0, s1_disp_reg[31:0]};

    logic        s2_valid_reg;
    ppcd_dec_t   s2_dec_reg;
    logic [31:0] s2_lo_sum_reg;
    logic        s2_carry_reg;
    logic [31:0] s2_pc_hi_reg;
    logic [63:0] s2_disp_reg;

    // ---------------------------------------------------------------
    // stage 3: high half with carry, pick absolute or relative target
    // ---------------------------------------------------------------
    logic [31:0] hi_sum;
    logic [63:0] target_next;

    assign hi_sum = s2_pc_hi_reg + s2_disp_reg[63:32] + {31'd0, s2_carry_reg};

    always_comb
    begin
        if (!s2_dec_reg.is_branch)
        begin
            target_next = '0;
        end
        else if (s2_dec_reg.absolute)
        begin
            target_next = s2_disp_reg;
        end
        else
        begin
            target_next = {hi_sum, s2_lo_sum_reg};
        end
    end

    logic        s3_valid_reg;
    ppcd_dec_t   s3_dec_reg;
    logic [63:0] s3_target_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_dec_reg    <= s1_dec_next;
        s1_disp_reg   <= s1_disp_next;
        s1_pc_reg     <= s1_pc_next;
        s2_dec_reg    <= s1_dec_reg;
        s2_lo_sum_reg <= lo_sum_next[31:0];
        s2_carry_reg  <= lo_sum_next[32];
        s2_pc_hi_reg  <= s1_pc_reg[63:32];
        s2_disp_reg   <= s1_disp_reg;
        s3_dec_reg    <= s2_dec_reg;
        s3_target_reg <= target_next;
    end

    // result ports
    assign busy          = 1'b0;
    assign done          = s3_valid_reg;
    assign recognized    = (s3_dec_reg.mnemonic != MN_NONE);
    assign mnemonic      = s3_dec_reg.mnemonic;
    assign reg_one       = s3_dec_reg.reg_fields[24:20];
    assign reg_two       = s3_dec_reg.reg_fields[19:15];
    assign reg_three     = s3_dec_reg.reg_fields[14:10];
    assign reg_four      = s3_dec_reg.reg_fields[9:5];
    assign reg_five      = s3_dec_reg.reg_fields[4:0];
    assign immediate     = s3_dec_reg.immediate;
    assign special_reg   = s3_dec_reg.special_reg;
    assign suffix_bits   = s3_dec_reg.suffix_bits;
    assign branch_target = s3_target_reg;

endmodule

`default_nettype wire

@@ rtl/ppcd_chk.sv @@
`default_nettype none

module ppcd_chk
    import ppcd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        recognized,
    input wire logic [6:0]  mnemonic,
    input wire logic [4:0]  reg_one,
    input wire logic [4:0]  reg_two,
    input wire logic [4:0]  reg_three,
    input wire logic [4:0]  reg_four,
    input wire logic [4:0]  reg_five,
    input wire logic [15:0] immediate,
    input wire logic [9:0]  special_reg,
    input wire logic [3:0]  suffix_bits,
    input wire logic [63:0] branch_target
);

    // every accepted transaction yields its result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after accept");

    // no result without a matching accepted transaction
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching transaction");

    // unrecognized words report all fields as zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !recognized) |-> (mnemonic == MN_NONE && suffix_bits == 4'd0 &&
            reg_one == 5'd0 && reg_two == 5'd0 && reg_three == 5'd0 &&
            reg_four == 5'd0 && reg_five == 5'd0 &&
            immediate == 16'd0 && special_reg == 10'd0 && branch_target == 64'd0))
        else $error("unrecognized word with nonzero fields");

    // only b and bc carry a target or the absolute flag
    a_branch_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mnemonic != MN_B && mnemonic != MN_BC) |->
            (branch_target == 64'd0 && !suffix_bits[SUF_A]))
        else $error("target or absolute flag on a non-branch");

endmodule

bind powerpc_instruction_decoder_top ppcd_chk u_ppcd_chk (.*);

`default_nettype wire

@@ test/ppcd_decode_checker.sv @@
`timescale 1ns / 1ps

module ppcd_decode_checker
    import ppcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] instr_word,
    input  logic [63:0] pc,
    input  logic        done,
    input  logic        recognized,
    input  logic [6:0]  mnemonic,
    input  logic [4:0]  reg_one,
    input  logic [4:0]  reg_two,
    input  logic [4:0]  reg_three,
    input  logic [4:0]  reg_four,
    input  logic [4:0]  reg_five,
    input  logic [15:0] immediate,
    input  logic [9:0]  special_reg,
    input  logic [3:0]  suffix_bits,
    input  logic [63:0] branch_target,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        recognized;
        logic [6:0]  mnemonic;
        logic [4:0]  reg_one;
        logic [4:0]  reg_two;
        logic [4:0]  reg_three;
        logic [4:0]  reg_four;
        logic [4:0]  reg_five;
        logic [15:0] immediate;
        logic [9:0]  special_reg;
        logic [3:0]  suffix_bits;
        logic [63:0] branch_target;
    } decode_result_t;

    typedef struct packed {
        logic [31:0]    word;
        decode_result_t fields;
    } decode_entry_t;

    decode_entry_t decodes_due [$];
    int            fails = 0;

    // d-form opcodes that map straight to one mnemonic
    function automatic logic [6:0] dform_mnemonic(input logic [5:0] op);
        case (op)
            OP_TDI:      return MN_TDI;
            OP_TWI:      return MN_TWI;
            OP_MULLI:    return MN_MULLI;
            OP_SUBFIC:   return MN_SUBFIC;
            OP_ADDIC:    return MN_ADDIC;
            OP_ADDIC_RC: return MN_ADDIC_RC;
            OP_ADDI:     return MN_ADDI;
            OP_ADDIS:    return MN_ADDIS;
            OP_RLWIMI:   return MN_RLWIMI;
            OP_RLWINM:   return MN_RLWINM;
            OP_RLWNM:    return MN_RLWNM;
            OP_ORI:      return MN_ORI;
            OP_ORIS:     return MN_ORIS;
            OP_XORI:     return MN_XORI;
            OP_XORIS:    return MN_XORIS;
            OP_ANDI_RC:  return MN_ANDI_RC;
            OP_ANDIS_RC: return MN_ANDIS_RC;
            OP_LWZ:      return MN_LWZ;
            OP_LWZU:     return MN_LWZU;
            OP_LBZ:      return MN_LBZ;
            OP_LBZU:     return MN_LBZU;
            OP_STW:      return MN_STW;
            OP_STWU:     return MN_STWU;
            OP_STB:      return MN_STB;
            OP_STBU:     return MN_STBU;
            OP_LHZ:      return MN_LHZ;
            OP_LHZU:     return MN_LHZU;
            OP_LHA:      return MN_LHA;
            OP_LHAU:     return MN_LHAU;
            OP_STH:      return MN_STH;
            OP_STHU:     return MN_STHU;
            OP_LMW:      return MN_LMW;
            OP_STMW:     return MN_STMW;
            OP_LFS:      return MN_LFS;
            OP_LFSU:     return MN_LFSU;
            OP_LFD:      return MN_LFD;
            OP_LFDU:     return MN_LFDU;
            OP_STFS:     return MN_STFS;
            OP_STFSU:    return MN_STFSU;
            OP_STFD:     return MN_STFD;
            OP_STFDU:    return MN_STFDU;
            default:     return MN_NONE;
        endcase
    endfunction

    function automatic decode_result_t decode_word(input logic [31:0] w, input logic [63:0] addr);
        decode_result_t r;
        logic [5:0]     op;
        logic [4:0]     rd;
        logic [4:0]     ra;
        logic [4:0]     rb;
        logic [9:0]     xo;
        logic [9:0]     spr;
        logic [6:0]     mn;
        logic [15:0]    imm;
        logic [9:0]     sreg;
        logic [3:0]     suf;
        logic [63:0]    disp;
        logic [63:0]    tgt;
        logic           upd_ok;
        logic           rc_form;
        op      = w[31:26];
        rd      = w[25:21];
        ra      = w[20:16];
        rb      = w[15:11];
        xo      = w[10:1];
        spr     = {rb, ra};
        mn      = MN_NONE;
        imm     = w[15:0];
        sreg    = '0;
        suf     = '0;
        disp    = '0;
        tgt     = '0;
        upd_ok  = (ra != 5'd0) && (ra != rd);
        rc_form = 1'b0;

        case (op)
            OP_CMPLI: if (!w[22]) mn = MN_CMPLI;
            OP_CMPI:  if (!w[22]) mn = MN_CMPI;
            OP_BC, OP_B:
            begin
                mn = (op == OP_BC) ? MN_BC : MN_B;
                if (op == OP_BC)
                    disp = {{48{w[15]}}, w[15:2], 2'b00};
                else
                    disp = {{38{w[25]}}, w[25:2], 2'b00};
                suf[SUF_L] = w[0];
                suf[SUF_A] = w[1];
                tgt = w[1] ? disp : addr + disp;
            end
            OP_GRP19:
            begin
                case (xo)
                    XO19_MCRF:   mn = MN_MCRF;
                    XO19_RFID:   mn = MN_RFID;
                    XO19_ISYNC:  mn = MN_ISYNC;
                    XO19_HRFID:  mn = MN_HRFID;
                    XO19_BCLR:   mn = MN_BCLR;
                    XO19_BCCTR:  mn = MN_BCCTR;
                    XO19_CRNOR:  mn = MN_CRNOR;
                    XO19_CRANDC: mn = MN_CRANDC;
                    XO19_CRXOR:  mn = MN_CRXOR;
                    XO19_CRNAND: mn = MN_CRNAND;
                    XO19_CRAND:  mn = MN_CRAND;
                    XO19_CREQV:  mn = MN_CREQV;
                    XO19_CRORC:  mn = MN_CRORC;
                    XO19_CROR:   mn = MN_CROR;
                    default:     mn = MN_NONE;
                endcase
                // link bit only on the register branches
                if (mn == MN_BCLR || mn == MN_BCCTR)
                    suf[SUF_L] = w[0];
            end
            OP_GRP31:
            begin
                case (xo)
                    XO31_CMP:    mn = MN_CMP;
                    XO31_TW:     mn = MN_TW;
                    XO31_LWARX:  mn = MN_LWARX;
                    XO31_LDX:    mn = MN_LDX;
                    XO31_LWZX:   mn = MN_LWZX;
                    XO31_CMPL:   mn = MN_CMPL;
                    XO31_MFMSR:  mn = MN_MFMSR;
                    XO31_MTMSR:  mn = MN_MTMSR;
                    XO31_LWZUX:  if (upd_ok) mn = MN_LWZUX;
                    XO31_OR:     mn = (rd == rb) ? MN_MR : MN_OR;
                    XO31_MULHDU:
                    begin
                        mn = MN_MULHDU;
                        rc_form = 1'b1;
                    end
                    XO31_MULHWU:
                    begin
                        mn = MN_MULHWU;
                        rc_form = 1'b1;
                    end
                    XO31_MULHD:
                    begin
                        mn = MN_MULHD;
                        rc_form = 1'b1;
                    end
                    XO31_MULHW:
                    begin
                        mn = MN_MULHW;
                        rc_form = 1'b1;
                    end
                    XO31_SLW:
                    begin
                        mn = MN_SLW;
                        rc_form = 1'b1;
                    end
                    XO31_CNTLZW:
                    begin
                        mn = MN_CNTLZW;
                        rc_form = 1'b1;
                    end
                    XO31_SLD:
                    begin
                        mn = MN_SLD;
                        rc_form = 1'b1;
                    end
                    XO31_AND:
                    begin
                        mn = MN_AND;
                        rc_form = 1'b1;
                    end
                    XO31_SRAW:
                    begin
                        mn = MN_SRAW;
                        rc_form = 1'b1;
                    end
                    XO31_SRAD:
                    begin
                        mn = MN_SRAD;
                        rc_form = 1'b1;
                    end
                    XO31_SRAWI:
                    begin
                        mn = MN_SRAWI;
                        rc_form = 1'b1;
                    end
                    XO31_EXTSH:
                    begin
                        mn = MN_EXTSH;
                        rc_form = 1'b1;
                    end
                    XO31_EXTSB:
                    begin
                        mn = MN_EXTSB;
                        rc_form = 1'b1;
                    end
                    XO31_EXTSW:
                    begin
                        mn = MN_EXTSW;
                        rc_form = 1'b1;
                    end
                    XO31_MFCR:
                    begin
                        if (w[20])
                        begin
                            mn = MN_MFOCRF;
                            sreg = {2'b00, w[19:12]};
                        end
                        else
                            mn = MN_MFCR;
                    end
                    XO31_MFSPR:
                    begin
                        sreg = spr;
                        mn = (spr == SPR_XER) ? MN_MFXER :
                             (spr == SPR_LR)  ? MN_MFLR  :
                             (spr == SPR_CTR) ? MN_MFCTR : MN_MFSPR;
                    end
                    XO31_MTSPR:
                    begin
                        sreg = spr;
                        mn = (spr == SPR_XER) ? MN_MTXER :
                             (spr == SPR_LR)  ? MN_MTLR  :
                             (spr == SPR_CTR) ? MN_MTCTR : MN_MTSPR;
                    end
                    default:
                    begin
                        // xo-form arithmetic, matched without the oe bit
                        case (xo[8:0])
                            XOA_SUBFC:  mn = MN_SUBFC;
                            XOA_ADDC:   mn = MN_ADDC;
                            XOA_SUBF:   mn = MN_SUBF;
                            XOA_NEG:    mn = MN_NEG;
                            XOA_SUBFE:  mn = MN_SUBFE;
                            XOA_ADDE:   mn = MN_ADDE;
                            XOA_SUBFZE: mn = MN_SUBFZE;
                            XOA_ADDZE:  mn = MN_ADDZE;
                            XOA_SUBFME: mn = MN_SUBFME;
                            XOA_MULLD:  mn = MN_MULLD;
                            XOA_ADDME:  mn = MN_ADDME;
                            XOA_MULLW:  mn = MN_MULLW;
                            XOA_ADD:    mn = MN_ADD;
                            XOA_DIVDU:  mn = MN_DIVDU;
                            XOA_DIVWU:  mn = MN_DIVWU;
                            XOA_DIVD:   mn = MN_DIVD;
                            XOA_DIVW:   mn = MN_DIVW;
                            default:    mn = MN_NONE;
                        endcase
                        if (mn != MN_NONE)
                        begin
                            suf[SUF_O] = w[10];
                            rc_form = 1'b1;
                        end
                    end
                endcase
            end
            OP_DS_LOAD:
            begin
                imm = {w[15:2], 2'b00};
                case (w[1:0])
                    2'd0:    mn = MN_LD;
                    2'd1:    if (upd_ok) mn = MN_LDU;
                    2'd2:    mn = MN_LWA;
                    default: mn = MN_NONE;
                endcase
            end
            OP_DS_STORE:
            begin
                imm = {w[15:2], 2'b00};
                if (w[1:0] == 2'd0)
                    mn = MN_STD;
                else if (w[1:0] == 2'd1 && ra != 5'd0)
                    mn = MN_STDU;
            end
            OP_LWZU, OP_LBZU, OP_LHZU, OP_LHAU:
                if (upd_ok) mn = dform_mnemonic(op);
            OP_STWU, OP_STBU, OP_STHU, OP_LFSU, OP_LFDU, OP_STFSU, OP_STFDU:
                if (ra != 5'd0) mn = dform_mnemonic(op);
            OP_LMW:
                if (ra < rd) mn = MN_LMW;
            OP_RLWIMI, OP_RLWINM, OP_RLWNM:
            begin
                mn = dform_mnemonic(op);
                rc_form = 1'b1;
            end
            default:
                mn = dform_mnemonic(op);
        endcase

        if (rc_form)
            suf[SUF_DOT] = w[0];

        r = '0;
        if (mn != MN_NONE)
        begin
            r.recognized    = 1'b1;
            r.mnemonic      = mn;
            r.reg_one       = rd;
            r.reg_two       = ra;
            r.reg_three     = rb;
            r.reg_four      = w[10:6];
            r.reg_five      = w[5:1];
            r.immediate     = imm;
            r.special_reg   = sreg;
            r.suffix_bits   = suf;
            r.branch_target = tgt;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] word,
                                   input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s mismatch for word %h: got %h, expected %h",
                 $time, field, word, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin : watch
        decode_entry_t  entry;
        decode_result_t seen;
        decode_result_t want;

        if (rst_n && start && !busy)
        begin
            entry.word   = instr_word;
            entry.fields = decode_word(instr_word, pc);
            decodes_due.push_back(entry);
        end

        if (rst_n && done)
        begin
            seen.recognized    = recognized;
            seen.mnemonic      = mnemonic;
            seen.reg_one       = reg_one;
            seen.reg_two       = reg_two;
            seen.reg_three     = reg_three;
            seen.reg_four      = reg_four;
            seen.reg_five      = reg_five;
            seen.immediate     = immediate;
            seen.special_reg   = special_reg;
            seen.suffix_bits   = suffix_bits;
            seen.branch_target = branch_target;
            if (decodes_due.size() == 0)
                report_mismatch("unrequested result", 32'h0, 64'(seen.mnemonic), 64'h0);
            else
            begin
                entry = decodes_due.pop_front();
                want  = entry.fields;
                if (seen.recognized !== want.recognized)
                    report_mismatch("recognized", entry.word,
                                    64'(seen.recognized), 64'(want.recognized));
                if (seen.mnemonic !== want.mnemonic)
                    report_mismatch("mnemonic", entry.word,
                                    64'(seen.mnemonic), 64'(want.mnemonic));
                if (seen.reg_one !== want.reg_one)
                    report_mismatch("reg_one", entry.word,
                                    64'(seen.reg_one), 64'(want.reg_one));
                if (seen.reg_two !== want.reg_two)
                    report_mismatch("reg_two", entry.word,
                                    64'(seen.reg_two), 64'(want.reg_two));
                if (seen.reg_three !== want.reg_three)
                    report_mismatch("reg_three", entry.word,
                                    64'(seen.reg_three), 64'(want.reg_three));
                if (seen.reg_four !== want.reg_four)
                    report_mismatch("reg_four", entry.word,
                                    64'(seen.reg_four), 64'(want.reg_four));
                if (seen.reg_five !== want.reg_five)
                    report_mismatch("reg_five", entry.word,
                                    64'(seen.reg_five), 64'(want.reg_five));
                if (seen.immediate !== want.immediate)
                    report_mismatch("immediate", entry.word,
                                    64'(seen.immediate), 64'(want.immediate));
                if (seen.special_reg !== want.special_reg)
                    report_mismatch("special_reg", entry.word,
                                    64'(seen.special_reg), 64'(want.special_reg));
                if (seen.suffix_bits !== want.suffix_bits)
                    report_mismatch("suffix_bits", entry.word,
                                    64'(seen.suffix_bits), 64'(want.suffix_bits));
                if (seen.branch_target !== want.branch_target)
                    report_mismatch("branch_target", entry.word,
                                    seen.branch_target, want.branch_target);
            end
        end

        fail_count    <= fails;
        pending_count <= decodes_due.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ppcd_pkg::*;

    // number of random transactions after the directed part
    localparam int RANDOM_ITEMS = 1700;
    // cycles with no transaction on either channel before giving up
    localparam int IDLE_LIMIT   = 1000;
    // the pipe is three deep, so this is plenty to flush it
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instr_word;
    logic [63:0] pc;
    logic        done;
    logic        recognized;
    logic [6:0]  mnemonic;
    logic [4:0]  reg_one;
    logic [4:0]  reg_two;
    logic [4:0]  reg_three;
    logic [4:0]  reg_four;
    logic [4:0]  reg_five;
    logic [15:0] immediate;
    logic [9:0]  special_reg;
    logic [3:0]  suffix_bits;
    logic [63:0] branch_target;
    int          fail_count;
    int          pending_count;

    // opcode pools for well-formed words; everything else comes from plain noise
    logic [5:0] dform_ops [0:22] = '{
        OP_TDI, OP_TWI, OP_MULLI, OP_SUBFIC, OP_CMPLI, OP_CMPI, OP_ADDIC, OP_ADDIC_RC,
        OP_ADDI, OP_ADDIS, OP_BC, OP_B, OP_RLWIMI, OP_RLWINM, OP_RLWNM, OP_ORI, OP_ORIS,
        OP_XORI, OP_XORIS, OP_ANDI_RC, OP_ANDIS_RC, OP_DS_LOAD, OP_DS_STORE
    };
    logic [9:0] xo19_ops [0:13] = '{
        XO19_MCRF, XO19_BCLR, XO19_RFID, XO19_CRNOR, XO19_CRANDC, XO19_ISYNC, XO19_CRXOR,
        XO19_CRNAND, XO19_CRAND, XO19_HRFID, XO19_CREQV, XO19_CRORC, XO19_CROR, XO19_BCCTR
    };
    logic [9:0] xo31_ops [0:26] = '{
        XO31_CMP, XO31_TW, XO31_MULHDU, XO31_MULHWU, XO31_MFCR, XO31_LWARX, XO31_LDX,
        XO31_LWZX, XO31_SLW, XO31_CNTLZW, XO31_SLD, XO31_AND, XO31_CMPL, XO31_LWZUX,
        XO31_MULHD, XO31_MULHW, XO31_MFMSR, XO31_MTMSR, XO31_MFSPR, XO31_OR, XO31_MTSPR,
        XO31_SRAW, XO31_SRAD, XO31_SRAWI, XO31_EXTSH, XO31_EXTSB, XO31_EXTSW
    };
    logic [8:0] arith_ops [0:16] = '{
        XOA_SUBFC, XOA_ADDC, XOA_SUBF, XOA_NEG, XOA_SUBFE, XOA_ADDE, XOA_SUBFZE, XOA_ADDZE,
        XOA_SUBFME, XOA_MULLD, XOA_ADDME, XOA_MULLW, XOA_ADD, XOA_DIVDU, XOA_DIVWU,
        XOA_DIVD, XOA_DIVW
    };

    powerpc_instruction_decoder_top dut (.*);

    // watches both channels, predicts every decode and counts mismatches
    ppcd_decode_checker decode_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // d-form layout: opcode, rt, ra, 16-bit field
    function automatic logic [31:0] d_word(input logic [5:0] op, input logic [4:0] rt,
                                           input logic [4:0] ra, input logic [15:0] d);
        return {op, rt, ra, d};
    endfunction

    // x-form layout: opcode, rt, ra, rb, extended opcode, record bit
    function automatic logic [31:0] x_word(input logic [5:0] op, input logic [4:0] rt,
                                           input logic [4:0] ra, input logic [4:0] rb,
                                           input logic [9:0] xo, input logic rc);
        return {op, rt, ra, rb, xo, rc};
    endfunction

    // mostly well-formed words with random operands, nudged toward the corner cases
    function automatic logic [31:0] make_word();
        logic [31:0]  w;
        logic [9:0]   alias_spr;
        int unsigned  pick;
        int unsigned  sel;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        // pure noise: reserved opcodes, bad extended opcodes and the like
        if (pick < 12)
            return w;
        if (pick < 40)
            w[31:26] = dform_ops[$urandom_range(0, 22)];
        else if (pick < 58)
            w[31:26] = OP_LWZ + 6'($urandom_range(0, OP_STFDU - OP_LWZ));
        else if (pick < 70)
        begin
            w[31:26] = OP_GRP19;
            w[10:1]  = xo19_ops[$urandom_range(0, 13)];
        end
        else if (pick < 86)
        begin
            w[31:26] = OP_GRP31;
            w[10:1]  = xo31_ops[$urandom_range(0, 26)];
        end
        else
        begin
            // oe bit stays random
            w[31:26] = OP_GRP31;
            w[9:1]   = arith_ops[$urandom_range(0, 16)];
        end

        // register coincidences that flip update forms, mr and the spr aliases
        case ($urandom_range(0, 7))
            0: w[20:16] = 5'd0;
            1: w[20:16] = w[25:21];
            2: w[15:11] = w[25:21];
            3:
            begin
                sel = $urandom_range(0, 2);
                alias_spr = (sel == 0) ? SPR_XER : (sel == 1) ? SPR_LR : SPR_CTR;
                w[20:16] = alias_spr[4:0];
                w[15:11] = alias_spr[9:5];
            end
            default: ;
        endcase
        return w;
    endfunction

    // addresses with extra weight near both ends so the branch add wraps
    function automatic logic [63:0] make_pc();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return '1;
            2:       return {32'h0, 32'($urandom)};
            3:       return {32'hffff_ffff, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // one command transaction; start stays high so back-to-back calls stream
    task automatic send_instr(input logic [31:0] w, input logic [63:0] addr);
        start      <= 1'b1;
        instr_word <= w;
        pc         <= addr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // watchdog: any accepted command or any result resets the count
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rst_n && start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int burst;
        int gap;
        rst_n      = 1'b0;
        start      = 1'b0;
        instr_word = '0;
        pc         = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and the special cases, streamed with no gaps
        send_instr(32'h0, 64'h0);                                    // all zero, unknown
        send_instr('1, '1);                                          // all ones
        send_instr(d_word(OP_B, 5'h1f, 5'h1f, 16'hfffd), 64'h0);     // bl back, wraps
        send_instr(d_word(OP_B, 5'h0f, 5'h1f, 16'hfffe), '1);        // ba, largest forward
        send_instr(d_word(OP_BC, 5'd20, 5'd0, 16'h8000), 64'h4000);  // bc, most negative
        send_instr(d_word(OP_BC, 5'd12, 5'd2, 16'h7fff), '1);        // bcla
        send_instr(x_word(OP_GRP19, 5'd20, 5'd0, 5'd0, XO19_BCLR, 1'b1), 64'h0);
        send_instr(x_word(OP_GRP31, 5'd3, SPR_XER[4:0], SPR_XER[9:5], XO31_MFSPR, 1'b0),
                   64'h0);
        send_instr(x_word(OP_GRP31, 5'd4, SPR_LR[4:0], SPR_LR[9:5], XO31_MFSPR, 1'b1),
                   64'h0);
        send_instr(x_word(OP_GRP31, 5'd5, SPR_CTR[4:0], SPR_CTR[9:5], XO31_MTSPR, 1'b0),
                   64'h0);
        send_instr(x_word(OP_GRP31, 5'd31, 5'h1f, 5'h1f, XO31_MTSPR, 1'b0), 64'h0);
        send_instr(x_word(OP_GRP31, 5'd7, 5'd4, 5'd7, XO31_OR, 1'b1), 64'h0);   // mr
        send_instr(x_word(OP_GRP31, 5'd7, 5'd4, 5'd8, XO31_OR, 1'b1), 64'h0);   // or
        send_instr(x_word(OP_GRP31, 5'd5, 5'h1a, 5'h15, XO31_MFCR, 1'b0), 64'h0); // mfocrf
        send_instr(x_word(OP_GRP31, 5'd1, 5'd2, 5'd3, {1'b1, XOA_ADD}, 1'b1), 64'h0);
        send_instr(d_word(OP_LWZU, 5'd3, 5'd0, 16'h0010), 64'h0);    // update, ra zero
        send_instr(d_word(OP_LWZU, 5'd3, 5'd3, 16'h0010), 64'h0);    // update, ra = rd
        send_instr(d_word(OP_LWZU, 5'd3, 5'd4, 16'hffff), 64'h0);
        send_instr(d_word(OP_STWU, 5'd3, 5'd0, 16'h0010), 64'h0);    // store update, ra zero
        send_instr(d_word(OP_LMW, 5'd20, 5'd19, 16'h0000), 64'h0);
        send_instr(d_word(OP_LMW, 5'd20, 5'd20, 16'h0000), 64'h0);   // ra not below rd
        send_instr(d_word(OP_CMPI, 5'b00010, 5'd3, 16'h8000), 64'h0); // reserved bit set
        send_instr(d_word(OP_CMPLI, 5'b11101, 5'd31, 16'hffff), 64'h0);
        send_instr(d_word(OP_DS_LOAD, 5'd4, 5'd5, 16'h1237), 64'h0); // bad ds selector
        send_instr(d_word(OP_DS_STORE, 5'd1, 5'd0, 16'hfffd), 64'h0); // stdu, ra zero

        // random: bursts of varying length, gaps land on every pipe stage
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            for (int k = 0; k < burst; k++)
            begin
                send_instr(make_word(), make_pc());
                sent++;
            end
            gap = $urandom_range(0, 6);
            // a zero gap keeps start high into the next burst
            if (gap != 0)
            begin
                start      <= 1'b0;
                instr_word <= $urandom;
                pc         <= {32'($urandom), 32'($urandom)};
                repeat (gap) @(posedge clk);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ppcd_pkg.sv
rtl/powerpc_instruction_decoder_top.sv
rtl/ppcd_chk.sv
test/ppcd_decode_checker.sv
test/tb_top.sv
